// File: hdl/bfg_pkg.sv
// Shared types and constants of the bilinear field gather unit.
`default_nettype none
package bfg_pkg;
    localparam int POINT_DEPTH = 4096;
    localparam int ADDR_W = $clog2(POINT_DEPTH);
    localparam int COORD_W = 12;
    localparam int RW_W = 13;
    localparam int IDX_W = COORD_W + RW_W + 1;
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
    localparam logic [RW_W-1:0] ROW_WIDTH_RESET = RW_W'(64);

    typedef enum logic {
        MODE_LOAD   = 1'b0,
        MODE_GATHER = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                   mode;
        logic                    bad;
        logic [3:0][ADDR_W-1:0]  addr;
        logic [3:0][31:0]        weight;
        logic [31:0]             data_x;
        logic [31:0]             data_y;
    } cmd_t;

    typedef struct packed {
        logic [31:0] grad_x;
        logic [31:0] grad_y;
        logic        err;
    } result_t;
endpackage
`default_nettype wire

// File: hdl/bfg_front.sv
// Front stage: registers items, forms corner addresses and checks their range.
`default_nettype none
module bfg_front
    import bfg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [RW_W-1:0]    row_width,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               mode,
    input  wire logic [11:0]        point_index,
    input  wire logic [31:0]        field_x,
    input  wire logic [31:0]        field_y,
    input  wire logic [COORD_W-1:0] corner_col,
    input  wire logic [COORD_W-1:0] corner_row,
    input  wire logic [3:0][31:0]   weights,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready,
    output cmd_t                    cmd
);
    logic                       valid_reg;
    mode_t                      mode_reg;
    logic [11:0]                pidx_reg;
    logic [31:0]                x_reg;
    logic [31:0]                y_reg;
    logic [COORD_W-1:0]         col_reg;
    logic [COORD_W+RW_W-1:0]    prod_reg;
    logic [RW_W-1:0]            rw_reg;
    logic [3:0][31:0]           w_reg;
    logic [IDX_W-1:0]           base;
    logic [3:0][IDX_W-1:0]      idx;
    logic                       drop;
    logic                       done;
    logic                       accept;

    always_comb
    begin
        base = IDX_W'(prod_reg) + IDX_W'(col_reg);
        idx[0] = base;
        idx[1] = base + IDX_W'(1);
        idx[2] = base + IDX_W'(rw_reg);
        idx[3] = base + IDX_W'(rw_reg) + IDX_W'(1);
        drop = (mode_reg == MODE_LOAD) && (IDX_W'(pidx_reg) >= IDX_W'(POINT_DEPTH));
        cmd.mode = mode_reg;
        cmd.bad = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (idx[k] >= IDX_W'(POINT_DEPTH))
                cmd.bad = 1'b1;
            cmd.addr[k] = ADDR_W'(idx[k]);
        end
        if (mode_reg == MODE_LOAD)
            cmd.addr[0] = ADDR_W'(pidx_reg);
        cmd.weight = w_reg;
        cmd.data_x = x_reg;
        cmd.data_y = y_reg;
        cmd_valid = valid_reg && !drop;
        done = valid_reg && (drop || cmd_ready);
        full = valid_reg && !done;
        accept = push && !full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (done)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode_t'(mode);
            pidx_reg <= point_index;
            x_reg <= field_x;
            y_reg <= field_y;
            col_reg <= corner_col;
            prod_reg <= (COORD_W+RW_W)'(corner_row) * (COORD_W+RW_W)'(row_width);
            rw_reg <= row_width;
            w_reg <= weights;
        end
    end
endmodule
`default_nettype wire

// File: hdl/bfg_cmd_queue.sv
// Short command queue between the front stage and the back end.
`default_nettype none
module bfg_cmd_queue
    import bfg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire cmd_t wr_cmd,
    output logic      rd_empty,
    input  wire logic rd_pop,
    output cmd_t      rd_cmd
);
    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic                 do_wr;
    logic                 do_rd;

    always_comb
    begin
        wr_ready = count_reg != CMD_CNT_W'(CMD_DEPTH);
        rd_empty = count_reg == '0;
        do_wr = wr_valid && wr_ready;
        do_rd = rd_pop && !rd_empty;
        rd_cmd = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end
endmodule
`default_nettype wire

// File: hdl/bfg_back.sv
// Back end: replicated field store, weighting pipeline and result queue.
`default_nettype none
module bfg_back
    import bfg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_empty,
    output logic      cmd_pop,
    input  wire cmd_t cmd,
    output logic      empty,
    input  wire logic pop,
    output result_t   result
);
    logic                  issue_load;
    logic                  issue_gather;
    logic [OUT_CNT_W-1:0]  pending;
    logic                  s1_valid_reg;
    logic                  s1_bad_reg;
    logic [3:0][31:0]      s1_w_reg;
    logic [3:0][63:0]      s1_rd_reg;
    logic                  s2_valid_reg;
    logic                  s2_bad_reg;
    logic [3:0][31:0]      s2_px_reg;
    logic [3:0][31:0]      s2_py_reg;
    logic                  s3_valid_reg;
    result_t               s3_res_reg;
    result_t               out_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  out_wr_reg;
    logic [OUT_PTR_W-1:0]  out_rd_reg;
    logic [OUT_CNT_W-1:0]  out_count_reg;
    logic                  out_pop;

    always_comb
    begin
        pending = out_count_reg + OUT_CNT_W'(s1_valid_reg) + OUT_CNT_W'(s2_valid_reg)
                + OUT_CNT_W'(s3_valid_reg);
        issue_load = !cmd_empty && (cmd.mode == MODE_LOAD);
        issue_gather = !cmd_empty && (cmd.mode == MODE_GATHER)
                     && (pending < OUT_CNT_W'(OUT_DEPTH));
        cmd_pop = issue_load || issue_gather;
        empty = out_count_reg == '0;
        out_pop = pop && !empty;
        result = out_reg[out_rd_reg];
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [63:0] mem [POINT_DEPTH];

        always_ff @(posedge clk)
        begin
            if (issue_load)
                mem[cmd.addr[0]] <= {cmd.data_y, cmd.data_x};
            if (issue_gather)
                s1_rd_reg[k] <= mem[cmd.addr[k]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_wr_reg <= '0;
            out_rd_reg <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= issue_gather;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s3_valid_reg)
                out_wr_reg <= (out_wr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : out_wr_reg + 1'b1;
            if (out_pop)
                out_rd_reg <= (out_rd_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : out_rd_reg + 1'b1;
            if (s3_valid_reg && !out_pop)
                out_count_reg <= out_count_reg + 1'b1;
            else if (out_pop && !s3_valid_reg)
                out_count_reg <= out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_gather)
        begin
            s1_bad_reg <= cmd.bad;
            s1_w_reg <= cmd.weight;
        end
        s2_bad_reg <= s1_bad_reg;
        for (int k = 0; k < 4; k++)
        begin
            s2_px_reg[k] <= s1_w_reg[k] * s1_rd_reg[k][31:0];
            s2_py_reg[k] <= s1_w_reg[k] * s1_rd_reg[k][63:32];
        end
        if (s2_bad_reg)
        begin
            s3_res_reg.grad_x <= '0;
            s3_res_reg.grad_y <= '0;
        end
        else
        begin
            s3_res_reg.grad_x <= s2_px_reg[0] + s2_px_reg[1] + s2_px_reg[2] + s2_px_reg[3];
            s3_res_reg.grad_y <= s2_py_reg[0] + s2_py_reg[1] + s2_py_reg[2] + s2_py_reg[3];
        end
        s3_res_reg.err <= s2_bad_reg;
        if (s3_valid_reg)
            out_reg[out_wr_reg] <= s3_res_reg;
    end
endmodule
`default_nettype wire

// File: hdl/bilinear_field_gather_unit.sv
// Top level of the bilinear field gather unit.
// The unit takes one item per clock while full is low. A load writes one grid point into
// all four copies of the field store; a gather reads its four corners at once, one per copy,
// and its result passes through address forming, the command queue, a store read, a multiply
// and an add before it enters the result queue. Loads give no result. Results wait in an
// eight-entry queue; a gather is held back while that queue and the pipeline together would
// overflow it.
`default_nettype none
module bilinear_field_gather_unit
    import bfg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               mode,
    input  wire logic [11:0]        point_index,
    input  wire logic signed [31:0] field_x,
    input  wire logic signed [31:0] field_y,
    input  wire logic [11:0]        corner_col,
    input  wire logic [11:0]        corner_row,
    input  wire logic signed [31:0] weight_nw,
    input  wire logic signed [31:0] weight_ne,
    input  wire logic signed [31:0] weight_sw,
    input  wire logic signed [31:0] weight_se,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      grad_x,
    output logic signed [31:0]      grad_y,
    output logic                    range_error
);
    logic [RW_W-1:0]  row_width_reg;
    logic [3:0][31:0] weights;
    logic             f_valid;
    logic             f_ready;
    cmd_t             f_cmd;
    logic             q_empty;
    logic             q_pop;
    cmd_t             q_cmd;
    result_t          res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_width_reg <= ROW_WIDTH_RESET;
        else if (psel && penable && pwrite && pready)
            row_width_reg <= pwdata[RW_W-1:0];
    end

    always_comb
    begin
        pready = 1'b1;
        prdata = 32'(row_width_reg) & {32{paddr == 2'd0}};
        weights = {weight_se, weight_sw, weight_ne, weight_nw};
        grad_x = res.grad_x;
        grad_y = res.grad_y;
        range_error = res.err;
    end

    bfg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_width   (row_width_reg),
        .push        (push),
        .full        (full),
        .mode        (mode),
        .point_index (point_index),
        .field_x     (field_x),
        .field_y     (field_y),
        .corner_col  (corner_col),
        .corner_row  (corner_row),
        .weights     (weights),
        .cmd_valid   (f_valid),
        .cmd_ready   (f_ready),
        .cmd         (f_cmd)
    );

    bfg_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_cmd   (f_cmd),
        .rd_empty (q_empty),
        .rd_pop   (q_pop),
        .rd_cmd   (q_cmd)
    );

    bfg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .cmd       (q_cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (res)
    );
endmodule
`default_nettype wire

// File: hdl/bfg_checker.sv
// Port-level checks of the bilinear field gather unit and their bind.
`default_nettype none
module bfg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pready,
    input wire logic [31:0] prdata,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] grad_x,
    input wire logic [31:0] grad_y,
    input wire logic        range_error
);
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && range_error |-> grad_x == 32'd0 && grad_y == 32'd0)
        else $error("range error result carries nonzero sums");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_prdata_width: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:13] == 19'd0)
        else $error("prdata upper bits set");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(grad_x) && $stable(grad_y)
        && $stable(range_error))
        else $error("waiting result changed before its transfer");
endmodule

bind bilinear_field_gather_unit bfg_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pready      (pready),
    .prdata      (prdata),
    .empty       (empty),
    .pop         (pop),
    .grad_x      (grad_x),
    .grad_y      (grad_y),
    .range_error (range_error)
);
`default_nettype wire

// File: dv/bilinear_field_gather_unit_tb.sv
// Self-checking testbench of the bilinear field gather unit with a queue driver and monitor.
`default_nettype none
module bilinear_field_gather_unit_tb;
    import bfg_pkg::*;

    localparam logic [1:0] REG_ROW_WIDTH = 2'd0;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        mode_t       mode;
        logic [11:0] pidx;
        logic [31:0] fx;
        logic [31:0] fy;
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] w [4];
    } field_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic push = 1'b0;
    logic full;
    logic mode = 1'b0;
    logic [11:0] point_index = '0;
    logic signed [31:0] field_x = '0;
    logic signed [31:0] field_y = '0;
    logic [11:0] corner_col = '0;
    logic [11:0] corner_row = '0;
    logic signed [31:0] weight_nw = '0;
    logic signed [31:0] weight_ne = '0;
    logic signed [31:0] weight_sw = '0;
    logic signed [31:0] weight_se = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic range_error;

    field_item_t item_queue [$];
    result_t     expected_sums [$];
    logic [31:0] point_x [POINT_DEPTH];
    logic [31:0] point_y [POINT_DEPTH];
    bit          point_loaded [POINT_DEPTH];
    logic [12:0] row_width_model = ROW_WIDTH_RESET;
    int          error_count = 0;
    int          transfers_in = 0;
    int          cycle_count = 0;
    int          send_gap = 0;
    int          take_gap = 0;
    bit          steady = 1'b0;
    logic        hold_off = 1'b0;

    bilinear_field_gather_unit u_top (.*);

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void corner_indices(field_item_t it, output longint unsigned idx [4]);
        longint unsigned nw;
        nw = longint'(it.row) * longint'(row_width_model) + longint'(it.col);
        idx[0] = nw;
        idx[1] = nw + 1;
        idx[2] = nw + row_width_model;
        idx[3] = nw + row_width_model + 1;
    endfunction

    function automatic result_t predict_gather(field_item_t it);
        result_t r;
        longint unsigned idx [4];
        logic [31:0] sx;
        logic [31:0] sy;
        corner_indices(it, idx);
        sx = '0;
        sy = '0;
        r.err = 1'b0;
        for (int k = 0; k < 4; k++)
            if (idx[k] >= POINT_DEPTH)
                r.err = 1'b1;
        if (!r.err)
            for (int k = 0; k < 4; k++)
            begin
                sx += it.w[k] * point_x[idx[k]];
                sy += it.w[k] * point_y[idx[k]];
            end
        r.grad_x = r.err ? '0 : sx;
        r.grad_y = r.err ? '0 : sy;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        if (error_count <= 30)
            $display("mismatch %s: got %h, expected %h", what, got, want);
    endtask

    // Loads are queued for every in-range corner not yet written, so no gather reads
    // an entry that was never loaded.
    task automatic add_load(logic [11:0] p, logic [31:0] x, logic [31:0] y);
        field_item_t it;
        it.mode = MODE_LOAD;
        it.pidx = p;
        it.fx = x;
        it.fy = y;
        it.col = 12'($urandom());
        it.row = 12'($urandom());
        for (int k = 0; k < 4; k++)
            it.w[k] = $urandom();
        point_loaded[p] = 1'b1;
        item_queue.push_back(it);
    endtask

    task automatic add_gather(logic [11:0] c, logic [11:0] r, logic [31:0] w0,
                              logic [31:0] w1, logic [31:0] w2, logic [31:0] w3);
        field_item_t it;
        longint unsigned idx [4];
        bit bad;
        it.mode = MODE_GATHER;
        it.pidx = 12'($urandom());
        it.fx = $urandom();
        it.fy = $urandom();
        it.col = c;
        it.row = r;
        it.w[0] = w0;
        it.w[1] = w1;
        it.w[2] = w2;
        it.w[3] = w3;
        corner_indices(it, idx);
        bad = 1'b0;
        for (int k = 0; k < 4; k++)
            if (idx[k] >= POINT_DEPTH)
                bad = 1'b1;
        if (!bad)
            for (int k = 0; k < 4; k++)
                if (!point_loaded[idx[k]])
                    add_load(12'(idx[k]), $urandom(), $urandom());
        item_queue.push_back(it);
    endtask

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 3))
            0: return 32'($signed($urandom_range(0, 512)) - 256);
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Many gathers keep their top-left corner within a small window, with all corners in range,
    // so that the corners are reused and few extra loads are needed.
    task automatic random_phase(int count);
        int nw;
        logic [11:0] c;
        logic [11:0] r;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) < 2)
                add_load(12'($urandom()), $urandom(), $urandom());
            else
            begin
                c = 12'($urandom());
                r = 12'($urandom());
                if ($urandom_range(0, 9) < 7 && row_width_model <= 4094)
                begin
                    nw = $urandom_range(0, (row_width_model > 4031)
                                        ? 4094 - row_width_model : 63);
                    r = (row_width_model == 0) ? 12'($urandom()) : 12'(nw / row_width_model);
                    c = 12'(nw - r * row_width_model);
                end
                add_gather(c, r, rand_weight(), rand_weight(), rand_weight(), rand_weight());
            end
        end
    endtask

    task automatic wait_idle();
        while (item_queue.size() != 0 || expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_width(logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_ROW_WIDTH;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        row_width_model = value[12:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                if (item_queue[0].mode == MODE_GATHER)
                    expected_sums.push_back(predict_gather(item_queue[0]));
                else
                begin
                    point_x[item_queue[0].pidx] = item_queue[0].fx;
                    point_y[item_queue[0].pidx] = item_queue[0].fy;
                end
                void'(item_queue.pop_front());
                transfers_in++;
            end
            if (!push || !full)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    push <= 1'b0;
                end
                else if (item_queue.size() != 0)
                begin
                    push <= 1'b1;
                    mode <= item_queue[0].mode;
                    point_index <= item_queue[0].pidx;
                    field_x <= item_queue[0].fx;
                    field_y <= item_queue[0].fy;
                    corner_col <= item_queue[0].col;
                    corner_row <= item_queue[0].row;
                    weight_nw <= item_queue[0].w[0];
                    weight_ne <= item_queue[0].w[1];
                    weight_sw <= item_queue[0].w[2];
                    weight_se <= item_queue[0].w[3];
                    send_gap = pick_gap();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_sums.size() == 0)
                    report("unexpected transfer", grad_x, 32'h0);
                else
                begin
                    if (grad_x !== expected_sums[0].grad_x)
                        report("grad_x", grad_x, expected_sums[0].grad_x);
                    if (grad_y !== expected_sums[0].grad_y)
                        report("grad_y", grad_y, expected_sums[0].grad_y);
                    if (range_error !== expected_sums[0].err)
                        report("range_error", 32'(range_error), 32'(expected_sums[0].err));
                    void'(expected_sums.pop_front());
                end
            end
            if (hold_off)
                pop <= 1'b0;
            else if (take_gap > 0)
            begin
                take_gap--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
                take_gap = pick_gap();
            end
        end
    end

    // One long receiver hold-off while the sender keeps pushing.
    initial
    begin
        while (transfers_in < 60)
            @(posedge clk);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] widths [7];
        widths = '{32'd1, 32'd0, 32'd4096, 32'd8191, 32'd37, 32'd0, 32'd64};
        widths[5] = $urandom_range(2, 300);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        add_load(12'd0, 32'h8000_0000, 32'h7fff_ffff);
        add_load(12'd4095, 32'h7fff_ffff, 32'h8000_0000);
        add_load(12'd1, 32'hffff_ffff, 32'h0000_0001);
        add_load(12'd64, 32'h0000_0000, 32'hffff_ffff);
        add_load(12'd65, 32'h1234_5678, 32'h8765_4321);
        add_gather(12'd0, 12'd0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h1);
        add_gather(12'd0, 12'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_gather(12'd0, 12'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        add_gather(12'd4095, 12'd4095, 32'h1, 32'h1, 32'h1, 32'h1);
        add_gather(12'd62, 12'd62, 32'h5, 32'h6, 32'h7, 32'h8);
        add_gather(12'd63, 12'd62, 32'h5, 32'h6, 32'h7, 32'h8);
        add_gather(12'd4095, 12'd0, 32'h2, 32'h3, 32'h4, 32'h5);
        add_load(12'd4094, 32'h0000_0100, 32'hffff_ff00);
        add_gather(12'd4094, 12'd0, 32'hffff_ffff, 32'h7fff_ffff, 32'h1, 32'h1);
        random_phase(100);
        wait_idle();

        for (int ph = 0; ph < 7; ph++)
        begin
            steady = (ph % 3 == 1);
            write_row_width(widths[ph]);
            if (widths[ph] == 0)
                add_gather(12'd4094, 12'd0, 32'h3, 32'h5, 32'h7, 32'h9);
            random_phase(60);
            wait_idle();
        end
        steady = 1'b0;

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
